FILE: rtl/tlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlca_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 32;
    localparam int DEPTH_W  = 10;

    typedef struct packed {
        logic                mode;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   parent_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [DEPTH_W-1:0]  node_depth;
        logic [NODE_W-1:0]   query_a;
        logic [NODE_W-1:0]   query_b;
    } t_in_word;

    typedef struct packed {
        logic [NODE_W-1:0] common_ancestor;
        logic [SUM_W-1:0]  path_weight;
    } t_out_word;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_W0,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_DRD,
        ST_Q_SWAP,
        ST_Q_UP,
        ST_Q_UPL,
        ST_Q_EQ,
        ST_Q_DN,
        ST_Q_DNS,
        ST_Q_FRD,
        ST_Q_FIN,
        ST_Q_SUM
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LD_W0,
        OP_LD_RD,
        OP_LD_WR,
        OP_Q_SWAP,
        OP_UP_RD,
        OP_UP_LIFT,
        OP_UP_SKIP,
        OP_DN_STEP,
        OP_LIFT_BOTH,
        OP_EMIT_ZERO,
        OP_EMIT_DIRECT,
        OP_EMIT_SUM
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   mode;
    } t_dp_cmd;

    typedef struct packed {
        logic oob;
        logic diff0;
        logic j_last;
        logic j_zero;
        logic a_eq_b;
    } t_dp_stat;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] x,
                                                 input logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tlca_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tlca_ctrl import tlca_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic     i_mode,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          busy,
    output logic          o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.mode = i_mode;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = (i_mode == MODE_QUERY) ? ST_Q_DRD : ST_LD_W0;
                end
            end
            ST_LD_W0: begin
                if (i_stat.oob) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.op = OP_LD_W0;
                    n_state  = i_stat.j_last ? ST_IDLE : ST_LD_RD;
                end
            end
            ST_LD_RD: begin
                o_cmd.op = OP_LD_RD;
                n_state  = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.op = OP_LD_WR;
                n_state  = i_stat.j_last ? ST_IDLE : ST_LD_RD;
            end
            ST_Q_DRD: begin
                if (i_stat.oob) begin
                    o_cmd.op = OP_EMIT_ZERO;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_Q_SWAP;
                end
            end
            ST_Q_SWAP: begin
                o_cmd.op = OP_Q_SWAP;
                n_state  = ST_Q_UP;
            end
            ST_Q_UP: begin
                if (i_stat.diff0) begin
                    o_cmd.op = OP_UP_RD;
                    n_state  = ST_Q_UPL;
                end else begin
                    o_cmd.op = OP_UP_SKIP;
                    n_state  = i_stat.j_last ? ST_Q_EQ : ST_Q_UP;
                end
            end
            ST_Q_UPL: begin
                o_cmd.op = OP_UP_LIFT;
                n_state  = i_stat.j_last ? ST_Q_EQ : ST_Q_UP;
            end
            ST_Q_EQ: begin
                if (i_stat.a_eq_b) begin
                    o_cmd.op = OP_EMIT_DIRECT;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_Q_DN;
                end
            end
            ST_Q_DN: begin
                n_state = ST_Q_DNS;
            end
            ST_Q_DNS: begin
                o_cmd.op = OP_DN_STEP;
                n_state  = i_stat.j_zero ? ST_Q_FRD : ST_Q_DN;
            end
            ST_Q_FRD: begin
                n_state = ST_Q_FIN;
            end
            ST_Q_FIN: begin
                o_cmd.op = OP_LIFT_BOTH;
                n_state  = ST_Q_SUM;
            end
            ST_Q_SUM: begin
                o_cmd.op = OP_EMIT_SUM;
                n_valid  = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: rtl/tlca_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tlca_datapath import tlca_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  wire logic     i_clk,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_word i_in,
    output t_dp_stat      o_stat,
    output t_out_word     o_result
);

    localparam int IW       = $clog2(MAX_NODES);
    localparam int ENTRIES  = MAX_NODES * LEVELS;
    localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);
    localparam logic [31:0]      MAX_U    = 32'(MAX_NODES);

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SUM_W-1:0]  weight;
    } t_jump;

    t_jump              r_jump_mem [ENTRIES];
    logic [DEPTH_W-1:0] r_depth_mem [MAX_NODES];

    t_jump              r_rd_a;
    t_jump              r_rd_b;
    logic [DEPTH_W-1:0] r_dep_a;
    logic [DEPTH_W-1:0] r_dep_b;

    logic [NODE_W-1:0]  r_a;
    logic [NODE_W-1:0]  r_b;
    logic [SUM_W-1:0]   r_wa;
    logic [SUM_W-1:0]   r_wb;
    logic [LVL_W-1:0]   r_j;
    logic [DEPTH_W-1:0] r_diff;
    logic [DEPTH_W-1:0] r_d;
    logic               r_oob;
    t_out_word          r_res;

    logic               ld_root;
    logic               ld_oob;
    logic               q_oob;
    logic [SUM_W-1:0]   sum_a;
    logic [SUM_W-1:0]   sum_b;
    logic [SUM_W-1:0]   sum_ab;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      addr_w;
    logic               wr_en;
    t_jump              wr_data;
    logic               a_shallow;

    function automatic logic [AW-1:0] f_addr(input logic [LVL_W-1:0] lvl,
                                             input logic [NODE_W-1:0] nd);
        return AW'(32'(lvl) * MAX_U + 32'(nd));
    endfunction

    always_comb begin
        ld_root   = (32'(i_in.parent_node) >= MAX_U) || (i_in.parent_node == i_in.node);
        ld_oob    = (32'(i_in.node) >= MAX_U);
        q_oob     = (32'(i_in.query_a) >= MAX_U) || (32'(i_in.query_b) >= MAX_U);
        sum_a     = sat_add(r_wa, r_rd_a.weight);
        sum_b     = sat_add(r_wb, r_rd_b.weight);
        sum_ab    = sat_add(r_wa, r_wb);
        // a load reads the parent-side row, everything else reads from r_a
        addr_a    = f_addr(r_j, (i_cmd.op == OP_LD_RD) ? r_b : r_a);
        addr_b    = f_addr(r_j, r_b);
        addr_w    = f_addr(r_j, r_a);
        wr_en     = (i_cmd.op == OP_LD_W0) || (i_cmd.op == OP_LD_WR);
        wr_data.node   = (i_cmd.op == OP_LD_W0) ? r_b : r_rd_a.node;
        wr_data.weight = (i_cmd.op == OP_LD_W0) ? r_wa : sum_a;
        a_shallow = (r_dep_a < r_dep_b);
    end

    always_ff @(posedge i_clk) begin
        r_rd_a  <= r_jump_mem[addr_a];
        r_rd_b  <= r_jump_mem[addr_b];
        r_dep_a <= r_depth_mem[IW'(r_a)];
        r_dep_b <= r_depth_mem[IW'(r_b)];
        if (wr_en) begin
            r_jump_mem[addr_w] <= wr_data;
        end
        if (i_cmd.op == OP_LD_W0) begin
            r_depth_mem[IW'(r_a)] <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_j  <= '0;
                r_wb <= '0;
                r_d  <= i_in.node_depth;
                if (i_cmd.mode == MODE_QUERY) begin
                    r_a   <= i_in.query_a;
                    r_b   <= i_in.query_b;
                    r_wa  <= '0;
                    r_oob <= q_oob;
                end else begin
                    r_a   <= i_in.node;
                    r_b   <= ld_root ? i_in.node : i_in.parent_node;
                    r_wa  <= ld_root ? '0 : SUM_W'(i_in.edge_weight);
                    r_oob <= ld_oob;
                end
            end
            OP_LD_RD: begin
                r_j <= r_j + LVL_W'(1);
            end
            OP_LD_WR: begin
                r_b  <= r_rd_a.node;
                r_wa <= sum_a;
            end
            OP_Q_SWAP: begin
                // keep the deeper node in r_a
                if (a_shallow) begin
                    r_a    <= r_b;
                    r_b    <= r_a;
                    r_diff <= r_dep_b - r_dep_a;
                end else begin
                    r_diff <= r_dep_a - r_dep_b;
                end
                r_j <= '0;
            end
            OP_UP_SKIP: begin
                r_diff <= r_diff >> 1;
                r_j    <= (r_j == LAST_LVL) ? r_j : r_j + LVL_W'(1);
            end
            OP_UP_LIFT: begin
                r_a    <= r_rd_a.node;
                r_wa   <= sum_a;
                r_diff <= r_diff >> 1;
                r_j    <= (r_j == LAST_LVL) ? r_j : r_j + LVL_W'(1);
            end
            OP_DN_STEP: begin
                if (r_rd_a.node != r_rd_b.node) begin
                    r_a  <= r_rd_a.node;
                    r_wa <= sum_a;
                    r_b  <= r_rd_b.node;
                    r_wb <= sum_b;
                end
                r_j <= (r_j == '0) ? r_j : r_j - LVL_W'(1);
            end
            OP_LIFT_BOTH: begin
                r_a  <= r_rd_a.node;
                r_wa <= sum_a;
                r_b  <= r_rd_b.node;
                r_wb <= sum_b;
            end
            OP_EMIT_ZERO: begin
                r_res <= '0;
            end
            OP_EMIT_DIRECT: begin
                r_res.common_ancestor <= r_a;
                r_res.path_weight     <= r_wa;
            end
            OP_EMIT_SUM: begin
                r_res.common_ancestor <= r_a;
                r_res.path_weight     <= sum_ab;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.oob    = r_oob;
    assign o_stat.diff0  = r_diff[0];
    assign o_stat.j_last = (r_j == LAST_LVL);
    assign o_stat.j_zero = (r_j == '0);
    assign o_stat.a_eq_b = (r_a == r_b);
    assign o_result      = r_res;

endmodule

`default_nettype wire

FILE: rtl/tree_lca_binary_lifting_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Lowest common ancestor over a rooted weighted tree, by binary lifting.
// Input: a word on i_in is taken at a clock edge with start high and busy low.
// mode 0 loads one node (parent, edge weight, depth); parents load before
// children. mode 1 queries two nodes and returns one word on o_result, marked
// by o_valid for exactly one cycle; the receiver has no way to stall it.
// Load of a node in range: one table row per level, level 0 written directly
// and each higher one by a read of the previous level's ancestor row, then a
// write. Query: the depths are read, the deeper node is lifted by the set bits
// of the depth gap and, unless one node is an ancestor of the other, both step
// down the levels and lift once more; a node out of range gives a zero result.
// The result strobe follows in the next cycle, in which a new word may already
// be taken. The pace is set by the registered read of the jump memory: each
// lift step waits for its row. Path sums saturate at all ones.
// Reset (synchronous, active low) returns the controller to idle and drops
// o_valid; table contents are kept and read undefined until loaded.

module tree_lca_binary_lifting_top import tlca_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_word i_in,
    output logic          busy,
    output logic          o_valid,
    output t_out_word     o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tlca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_in.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    tlca_datapath #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_in     (i_in),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_capture_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_CAPTURE) |-> (start && !busy))
        else $error("word captured outside an accept");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");
`endif

endmodule

`default_nettype wire
